FILE: rtl/box_vs_tile_mask_collision_defines.svh
// Assertion macros for the box versus tile mask collision block
`ifndef BOX_VS_TILE_MASK_COLLISION_DEFINES_SVH
`define BOX_VS_TILE_MASK_COLLISION_DEFINES_SVH
// same-cycle implication, clocked on clk, disabled in reset
`define BVT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define BVT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/bvtmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvtmc_pkg
// Types and constants of the box versus tile mask collision block.
// ----------------------------------------------------------------------------
package bvtmc_pkg;
	localparam int MAX_CHUNKS      = 16;
	localparam int MAX_CHUNK_TILES = 32;
	localparam int COORD_BITS      = 24;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_MASK  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [2:0] REG_TILE_W = 3'd0;
	localparam logic [2:0] REG_TILE_H = 3'd1;
	localparam logic [2:0] REG_COLS   = 3'd2;
	localparam logic [2:0] REG_ROWS   = 3'd3;

	typedef struct packed {
		logic [1:0]                   cmd;
		logic [3:0]                   slot;
		logic                         slot_enable;
		logic signed [COORD_BITS-1:0] origin_x;
		logic signed [COORD_BITS-1:0] origin_y;
		logic [4:0]                   row_index;
		logic [31:0]                  row_bits;
		logic signed [COORD_BITS-1:0] box_min_x;
		logic signed [COORD_BITS-1:0] box_min_y;
		logic signed [COORD_BITS-1:0] box_max_x;
		logic signed [COORD_BITS-1:0] box_max_y;
	} item_t;

	typedef struct packed {
		logic        colliding;
		logic [14:0] tiles_tested;
		logic [4:0]  active_chunks;
	} result_t;
endpackage

FILE: rtl/box_vs_tile_mask_collision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_vs_tile_mask_collision
// Box against per-slot blocked tile masks held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
// Drive item and raise start; the beat is taken when start is high and busy
// is low. Load and mask commands complete in that cycle and give no result.
// A query raises busy and walks the slots: a disabled slot is passed over
// in one state; an enabled slot has its origin read and tested, then its
// tile range found by restoring division, one quotient bit per step, then
// each mask row in range read and tested (memory read, then row test).
// The walk stops at the first row with a hit. The result appears on result
// for one cycle with done high, in the cycle busy falls. The receiver cannot
// stall; done is not held. Configuration: cfg_we with cfg_index and cfg_data,
// taken at once; the user must write only while idle, the block itself does
// not enforce it. Reset clears slot enables and restores register defaults;
// origin and mask memories hold no reset value and must be written first.
`include "box_vs_tile_mask_collision_defines.svh"
module box_vs_tile_mask_collision (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bvtmc_pkg::item_t    item,
	output logic                done,
	output bvtmc_pkg::result_t  result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [8:0]          cfg_data
);
	import bvtmc_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SLOT   = 3'd1;
	localparam logic [2:0] ST_ORIG   = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_ROWRD  = 3'd4;
	localparam logic [2:0] ST_ROWCHK = 3'd5;

	logic [2:0]  state_q;
	logic [8:0]  tw_q, th_q;
	logic [5:0]  cols_q, rows_q;
	logic [MAX_CHUNKS-1:0] valid_q;

	logic [2*COORD_BITS-1:0] orig_mem [MAX_CHUNKS];
	logic [31:0]             mask_mem [MAX_CHUNKS*MAX_CHUNK_TILES];
	logic [2*COORD_BITS-1:0] orig_rd_q;
	logic [31:0]             mask_rd_q;

	logic signed [COORD_BITS-1:0] bx0_q, by0_q, bx1_q, by1_q;
	logic [13:0] ctx_q, cty_q;
	logic [4:0]  s_q;
	logic [4:0]  ty_q;
	logic [2:0]  step_q;
	logic [14:0] tested_q;
	logic [4:0]  active_q;
	logic        done_q;
	result_t     result_q;

	logic [13:0] rem_q [4];
	logic [4:0]  lq_q  [4];
	logic        fix_q [4];

	logic [8:0]  twe, the;
	logic [5:0]  colse, rowse;
	logic        accept;

	logic signed [COORD_BITS:0] ox, oy;
	logic signed [COORD_BITS:0] ld [4];
	logic [13:0] lc [4];
	logic [5:0]  ln [4];
	logic [8:0]  ldiv [4];
	logic [13:0] nrem [4];
	logic [4:0]  nq [4];
	logic        no_overlap;

	logic [31:0] range_m, hit_m;
	logic [4:0]  hit_p;
	logic [4:0]  x0, x1, y1;

	assign twe   = (tw_q == 9'd0) ? 9'd1 : tw_q;
	assign the   = (th_q == 9'd0) ? 9'd1 : th_q;
	assign colse = (cols_q == 6'd0) ? 6'd1 : ((cols_q > 6'd32) ? 6'd32 : cols_q);
	assign rowse = (rows_q == 6'd0) ? 6'd1 : ((rows_q > 6'd32) ? 6'd32 : rows_q);
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	assign ox = {orig_rd_q[2*COORD_BITS-1], orig_rd_q[2*COORD_BITS-1:COORD_BITS]};
	assign oy = {orig_rd_q[COORD_BITS-1], orig_rd_q[COORD_BITS-1:0]};

	assign x0 = lq_q[0];
	assign x1 = lq_q[1];
	assign y1 = lq_q[3];

	always_comb begin
		ld[0] = {bx0_q[COORD_BITS-1], bx0_q} - ox;
		ld[1] = {bx1_q[COORD_BITS-1], bx1_q} - ox;
		ld[2] = {by0_q[COORD_BITS-1], by0_q} - oy;
		ld[3] = {by1_q[COORD_BITS-1], by1_q} - oy;
		lc[0] = ctx_q; lc[1] = ctx_q; lc[2] = cty_q; lc[3] = cty_q;
		ln[0] = colse; ln[1] = colse; ln[2] = rowse; ln[3] = rowse;
		ldiv[0] = twe; ldiv[1] = twe; ldiv[2] = the; ldiv[3] = the;
		no_overlap = ld[1][COORD_BITS] || (ld[0] > $signed({11'd0, ctx_q}))
			|| ld[3][COORD_BITS] || (ld[2] > $signed({11'd0, cty_q}));
		for (int i = 0; i < 4; i++) begin
			logic [13:0] sh;
			sh = {5'd0, ldiv[i]} << step_q;
			nrem[i] = rem_q[i];
			nq[i]   = lq_q[i];
			if (!fix_q[i] && rem_q[i] >= sh) begin
				nrem[i] = rem_q[i] - sh;
				nq[i][step_q] = 1'b1;
			end
		end
	end

	always_comb begin
		range_m = ({32{1'b1}} << x0) & ({32{1'b1}} >> (5'd31 - x1));
		hit_m   = mask_rd_q & range_m;
		hit_p   = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (hit_m[i]) hit_p = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.cmd == CMD_LOAD)
			orig_mem[item.slot] <= {item.origin_x, item.origin_y};
		if (accept && item.cmd == CMD_MASK)
			mask_mem[{item.slot, item.row_index}] <= item.row_bits;
		orig_rd_q <= orig_mem[s_q[3:0]];
		mask_rd_q <= mask_mem[{s_q[3:0], ty_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q    <= 9'd32;
			th_q    <= 9'd32;
			cols_q  <= 6'd25;
			rows_q  <= 6'd25;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TILE_W: tw_q   <= cfg_data;
				REG_TILE_H: th_q   <= cfg_data;
				REG_COLS:   cols_q <= cfg_data[5:0];
				REG_ROWS:   rows_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.cmd == CMD_LOAD)
						valid_q[item.slot] <= item.slot_enable;
					if (accept && item.cmd == CMD_QUERY)
						state_q <= ST_SLOT;
				end
				ST_SLOT: begin
					if (s_q == 5'(MAX_CHUNKS)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (valid_q[s_q[3:0]]) begin
						state_q <= ST_ORIG;
					end
				end
				ST_ORIG: state_q <= no_overlap ? ST_SLOT : ST_DIV;
				ST_DIV: if (step_q == 3'd0) state_q <= ST_ROWRD;
				ST_ROWRD: begin
					if (ty_q > y1 || x0 > x1) state_q <= ST_SLOT;
					else state_q <= ST_ROWCHK;
				end
				ST_ROWCHK: begin
					if (hit_m != 32'd0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (ty_q == y1) begin
						state_q <= ST_SLOT;
					end else begin
						state_q <= ST_ROWRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				bx0_q    <= item.box_min_x;
				by0_q    <= item.box_min_y;
				bx1_q    <= item.box_max_x;
				by1_q    <= item.box_max_y;
				ctx_q    <= {8'd0, colse} * {5'd0, twe};
				cty_q    <= {8'd0, rowse} * {5'd0, the};
				s_q      <= 5'd0;
				tested_q <= 15'd0;
				active_q <= 5'd0;
			end
			ST_SLOT: begin
				if (s_q == 5'(MAX_CHUNKS)) begin
					result_q <= '{colliding: 1'b0, tiles_tested: tested_q,
						active_chunks: active_q};
				end else if (valid_q[s_q[3:0]]) begin
					active_q <= active_q + 5'd1;
				end else begin
					s_q <= s_q + 5'd1;
				end
			end
			ST_ORIG: begin
				if (no_overlap) s_q <= s_q + 5'd1;
				step_q <= 3'd4;
				for (int i = 0; i < 4; i++) begin
					rem_q[i] <= ld[i][13:0];
					if (ld[i][COORD_BITS]) begin
						lq_q[i]  <= 5'd0;
						fix_q[i] <= 1'b1;
					end else if (ld[i] >= $signed({11'd0, lc[i]})) begin
						lq_q[i]  <= 5'(ln[i] - 6'd1);
						fix_q[i] <= 1'b1;
					end else begin
						lq_q[i]  <= 5'd0;
						fix_q[i] <= 1'b0;
					end
				end
			end
			ST_DIV: begin
				for (int i = 0; i < 4; i++) begin
					rem_q[i] <= nrem[i];
					lq_q[i]  <= nq[i];
				end
				ty_q   <= nq[2];
				step_q <= step_q - 3'd1;
			end
			ST_ROWRD: begin
				if (ty_q > y1 || x0 > x1) s_q <= s_q + 5'd1;
			end
			ST_ROWCHK: begin
				if (hit_m != 32'd0) begin
					result_q <= '{colliding: 1'b1,
						tiles_tested: tested_q + 15'(hit_p - x0) + 15'd1,
						active_chunks: active_q};
				end else begin
					tested_q <= tested_q + 15'(x1 - x0) + 15'd1;
					if (ty_q == y1) s_q <= s_q + 5'd1;
					else ty_q <= ty_q + 5'd1;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	`BVT_ASSERT_NEXT(a_no_done_from_idle, state_q == ST_IDLE, !done)
	`BVT_ASSERT_NOW(a_done_idle, done, !busy)
	`BVT_ASSERT_NOW(a_hit_counts, done && result.colliding, result.tiles_tested != 15'd0)
	`BVT_ASSERT_NOW(a_active_bound, done, result.active_chunks <= 5'd16)
endmodule
